// File: src/immix_block_line_sweep_defines.svh
// ----------------------------------------------------------------------------
// immix block line sweep assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef IMMIX_BLOCK_LINE_SWEEP_DEFINES_SVH
`define IMMIX_BLOCK_LINE_SWEEP_DEFINES_SVH

// same-cycle implication
`define IBLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibls check failed");

// next-cycle implication
`define IBLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibls check failed");

`endif

// File: src/ibls_pkg.sv
// ----------------------------------------------------------------------------
// ibls_pkg
// types, codes and sizes shared by the line sweep modules
// ----------------------------------------------------------------------------
package ibls_pkg;

   localparam int LINES_PER_BLOCK = 128;
   localparam int LC_W            = 8;
   localparam int AT_W            = 7;
   localparam int MAX_RES         = 5;
   localparam int IDX_W           = $clog2(MAX_RES);
   localparam int CNT_W           = $clog2(MAX_RES + 1);
   localparam int Q_DEPTH         = 4;
   localparam int Q_PTR_W         = $clog2(Q_DEPTH);
   localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);
   localparam int LBYTES_W        = 17;
   localparam int BBYTES_W        = 25;
   localparam int CSR_W           = 25;
   localparam int CSR_IDX_W       = 1;
   localparam int BYTES_W         = 40;
   localparam int COUNT_W         = 32;

   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [LC_W-1:0]    LAST_LINE = LC_W'(LINES_PER_BLOCK - 1);
   localparam logic [LC_W-1:0]    END_MARK  = LC_W'(LINES_PER_BLOCK);

   localparam logic [LBYTES_W-1:0] LINE_BYTES_RST  = LBYTES_W'(256);
   localparam logic [BBYTES_W-1:0] BLOCK_BYTES_RST = BBYTES_W'(32768);

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 1'b1;

   localparam logic CMD_LINE  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      EV_SWEEP = 3'd0,
      EV_CLEAR = 3'd1,
      EV_FIRST = 3'd2,
      EV_NEXT  = 3'd3,
      EV_SIZE  = 3'd4,
      EV_DONE  = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      OC_FREE        = 2'd0,
      OC_RECYCLABLE  = 2'd1,
      OC_UNAVAILABLE = 2'd2
   } outcome_type;

   typedef struct packed {
      logic command;
      logic block_marked;
      logic line_marked;
   } req_type;

   typedef struct packed {
      event_type           event_res;
      logic [AT_W-1:0]     line_at;
      logic [LC_W-1:0]     value;
      logic                is_end_marker;
      outcome_type         block_outcome;
      logic [BYTES_W-1:0]  free_bytes_total;
      logic [COUNT_W-1:0]  free_block_count;
      logic [COUNT_W-1:0]  recycled_block_count;
      logic                last;
   } rsp_type;

   typedef struct packed {
      event_type       ev;
      logic [AT_W-1:0] at;
      logic [LC_W-1:0] value;
      logic            endm;
      outcome_type     outcome;
   } res_type;

   typedef struct packed {
      res_type [MAX_RES-1:0] slot;
      logic [CNT_W-1:0]      count;
      logic [BYTES_W-1:0]    free_bytes;
      logic [COUNT_W-1:0]    free_blocks;
      logic [COUNT_W-1:0]    recycled_blocks;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic res_type mk_res(event_type ev, logic [LC_W-1:0] at,
                                      logic [LC_W-1:0] value, logic endm,
                                      outcome_type outcome);
      res_type r;
      r.ev      = ev;
      r.at      = at[AT_W-1:0];
      r.value   = value;
      r.endm    = endm;
      r.outcome = outcome;
      return r;
   endfunction

endpackage

// File: src/ibls_queue.sv
// ----------------------------------------------------------------------------
// ibls_queue
// short fifo of classified line words between front and back
// ----------------------------------------------------------------------------
module ibls_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ibls_pkg::item_type  push_item,
   input  logic                pop,
   output ibls_pkg::item_type  head_item,
   output ibls_pkg::qstat_type stat
);

   ibls_pkg::item_type                 mem_ff [ibls_pkg::Q_DEPTH];
   logic [ibls_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ibls_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ibls_pkg::Q_CNT_W-1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == ibls_pkg::Q_CNT_W'(ibls_pkg::Q_DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

// File: src/ibls_front.sv
// ----------------------------------------------------------------------------
// ibls_front
// takes line words, tracks holes and totals, builds the result list per word
// ----------------------------------------------------------------------------
module ibls_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ibls_pkg::req_type                   req_word,
   input  logic                                csr_we,
   input  logic [ibls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ibls_pkg::CSR_W-1:0]          csr_wdata,
   input  ibls_pkg::qstat_type                 qstat,
   output logic                                push,
   output ibls_pkg::item_type                  push_item
);

   logic [ibls_pkg::LBYTES_W-1:0] line_bytes_ff;
   logic [ibls_pkg::BBYTES_W-1:0] block_bytes_ff;

   logic [ibls_pkg::LC_W-1:0]    lc_ff, lc_in;
   logic                         in_run_ff, in_run_in;
   logic                         have_hole_ff, have_hole_in;
   logic [ibls_pkg::LC_W-1:0]    hole_start_ff, hole_start_in;
   logic [ibls_pkg::LC_W-1:0]    run_len_ff, run_len_in;
   logic [ibls_pkg::BYTES_W-1:0] free_bytes_ff, free_bytes_in;
   logic [ibls_pkg::COUNT_W-1:0] free_blocks_ff, free_blocks_in;
   logic [ibls_pkg::COUNT_W-1:0] recycled_ff, recycled_in;

   logic                          accept;
   logic                          at_end;
   logic                          add_en;
   logic [ibls_pkg::BBYTES_W-1:0] amount;
   logic [ibls_pkg::BYTES_W:0]    sum;
   logic                          bump_free;
   logic                          bump_rec;
   logic                          restart;
   logic [ibls_pkg::CNT_W-1:0]    n;
   ibls_pkg::res_type [ibls_pkg::MAX_RES-1:0] slots;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign at_end    = (lc_ff >= ibls_pkg::LAST_LINE);

   always_comb begin
      lc_in         = lc_ff;
      in_run_in     = in_run_ff;
      have_hole_in  = have_hole_ff;
      hole_start_in = hole_start_ff;
      run_len_in    = run_len_ff;
      add_en        = 1'b0;
      amount        = '0;
      bump_free     = 1'b0;
      bump_rec      = 1'b0;
      restart       = 1'b0;
      n             = '0;
      slots         = '0;
      if (!req_word.block_marked) begin
         if (at_end) begin
            slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_DONE, lc_ff, '0, 1'b0,
                                        ibls_pkg::OC_FREE);
            n         = n + 1'b1;
            add_en    = 1'b1;
            amount    = block_bytes_ff;
            bump_free = 1'b1;
            restart   = 1'b1;
         end else begin
            lc_in = lc_ff + 1'b1;
         end
      end else begin
         if (req_word.line_marked) begin
            if (in_run_ff) begin
               slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_SIZE, hole_start_ff,
                                           run_len_ff, 1'b0, ibls_pkg::OC_FREE);
               n         = n + 1'b1;
               in_run_in = 1'b0;
            end
            slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_SWEEP, lc_ff, '0, 1'b0,
                                        ibls_pkg::OC_FREE);
            n = n + 1'b1;
         end else begin
            if (!in_run_ff) begin
               if (!have_hole_ff) begin
                  slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_FIRST, lc_ff, lc_ff,
                                              1'b0, ibls_pkg::OC_FREE);
               end else begin
                  slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_NEXT, hole_start_ff,
                                              lc_ff, 1'b0, ibls_pkg::OC_FREE);
               end
               n             = n + 1'b1;
               hole_start_in = lc_ff;
               in_run_in     = 1'b1;
               have_hole_in  = 1'b1;
               run_len_in    = '0;
            end
            slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_CLEAR, lc_ff, '0, 1'b0,
                                        ibls_pkg::OC_FREE);
            n          = n + 1'b1;
            run_len_in = run_len_in + 1'b1;
            add_en     = 1'b1;
            amount     = ibls_pkg::BBYTES_W'(line_bytes_ff);
         end
         if (at_end) begin
            if (in_run_in) begin
               slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_SIZE, hole_start_in,
                                           run_len_in, 1'b0, ibls_pkg::OC_FREE);
               n = n + 1'b1;
            end
            if (have_hole_in) begin
               slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_NEXT, hole_start_in,
                                           ibls_pkg::END_MARK, 1'b1,
                                           ibls_pkg::OC_FREE);
               n = n + 1'b1;
               slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_DONE, lc_ff, '0, 1'b0,
                                           ibls_pkg::OC_RECYCLABLE);
               n        = n + 1'b1;
               bump_rec = 1'b1;
            end else begin
               slots[n] = ibls_pkg::mk_res(ibls_pkg::EV_DONE, lc_ff, '0, 1'b0,
                                           ibls_pkg::OC_UNAVAILABLE);
               n = n + 1'b1;
            end
            restart = 1'b1;
         end else begin
            lc_in = lc_ff + 1'b1;
         end
      end
      if (restart) begin
         lc_in         = '0;
         in_run_in     = 1'b0;
         have_hole_in  = 1'b0;
         hole_start_in = '0;
         run_len_in    = '0;
      end
   end

   // saturating totals
   always_comb begin
      sum            = {1'b0, free_bytes_ff} + (ibls_pkg::BYTES_W + 1)'(amount);
      free_bytes_in  = free_bytes_ff;
      free_blocks_in = free_blocks_ff;
      recycled_in    = recycled_ff;
      if (add_en) begin
         if (sum >= {1'b0, ibls_pkg::BYTES_MAX}) begin
            free_bytes_in = ibls_pkg::BYTES_MAX;
         end else begin
            free_bytes_in = sum[ibls_pkg::BYTES_W-1:0];
         end
      end
      if (bump_free && free_blocks_ff != ibls_pkg::COUNT_MAX) begin
         free_blocks_in = free_blocks_ff + 1'b1;
      end
      if (bump_rec && recycled_ff != ibls_pkg::COUNT_MAX) begin
         recycled_in = recycled_ff + 1'b1;
      end
   end

   // skipped lines give no result and are not queued
   always_comb begin
      push                      = accept && (req_word.command == ibls_pkg::CMD_LINE)
                                  && (n != '0);
      push_item.slot            = slots;
      push_item.count           = n;
      push_item.free_bytes      = free_bytes_in;
      push_item.free_blocks     = free_blocks_in;
      push_item.recycled_blocks = recycled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff  <= ibls_pkg::LINE_BYTES_RST;
         block_bytes_ff <= ibls_pkg::BLOCK_BYTES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ibls_pkg::CSR_LINE_BYTES: begin
               line_bytes_ff <= csr_wdata[ibls_pkg::LBYTES_W-1:0];
            end
            ibls_pkg::CSR_BLOCK_BYTES: begin
               block_bytes_ff <= csr_wdata[ibls_pkg::BBYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff          <= '0;
         in_run_ff      <= 1'b0;
         have_hole_ff   <= 1'b0;
         hole_start_ff  <= '0;
         run_len_ff     <= '0;
         free_bytes_ff  <= '0;
         free_blocks_ff <= '0;
         recycled_ff    <= '0;
      end else if (accept) begin
         if (req_word.command == ibls_pkg::CMD_CLEAR) begin
            free_bytes_ff  <= '0;
            free_blocks_ff <= '0;
            recycled_ff    <= '0;
         end else begin
            lc_ff          <= lc_in;
            in_run_ff      <= in_run_in;
            have_hole_ff   <= have_hole_in;
            hole_start_ff  <= hole_start_in;
            run_len_ff     <= run_len_in;
            free_bytes_ff  <= free_bytes_in;
            free_blocks_ff <= free_blocks_in;
            recycled_ff    <= recycled_in;
         end
      end
   end

endmodule

// File: src/ibls_back.sv
// ----------------------------------------------------------------------------
// ibls_back
// drains each queued word's result list, one result word per unstalled cycle
// ----------------------------------------------------------------------------
module ibls_back (
   input  logic                clock,
   input  logic                reset,
   input  ibls_pkg::item_type  head_item,
   input  ibls_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ibls_pkg::rsp_type   rsp_word
);

   logic [ibls_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ibls_pkg::rsp_type          rsp_word_ff, rsp_word_in;
   logic                       load;
   logic                       take;
   logic                       is_last;
   ibls_pkg::res_type          cur;

   always_comb begin
      load    = !rsp_valid_ff || !rsp_stall;
      take    = load && !qstat.empty;
      cur     = head_item.slot[idx_ff];
      is_last = (ibls_pkg::CNT_W'(idx_ff) + 1'b1 == head_item.count);
      pop     = take && is_last;
      idx_in  = idx_ff;
      if (take) begin
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = take;
      end
      rsp_word_in.event_res            = cur.ev;
      rsp_word_in.line_at              = cur.at;
      rsp_word_in.value                = cur.value;
      rsp_word_in.is_end_marker        = cur.endm;
      rsp_word_in.block_outcome        = cur.outcome;
      rsp_word_in.free_bytes_total     = head_item.free_bytes;
      rsp_word_in.free_block_count     = head_item.free_blocks;
      rsp_word_in.recycled_block_count = head_item.recycled_blocks;
      rsp_word_in.last                 = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: src/immix_block_line_sweep.sv
// ----------------------------------------------------------------------------
// immix_block_line_sweep
// line sweeper for collector blocks: hole links, clear events and free totals
//
//   channel   ports                         moves
//   req       req_valid req_stall req_word  one line or clear command word
//   rsp       rsp_valid rsp_stall rsp_word  one sweep event word
//   csr       csr_we csr_index csr_wdata    line_bytes, block_bytes writes
//
// a req word is taken while the queue has room
// each line word gives 0 to 5 rsp words, a clear word none; sent one per cycle unless rsp stall holds
// sustained rate is set by the back end: one rsp word per unstalled cycle
// reset is synchronous and empties the queue and the output register
// rsp stall holds the output register; req stall rises when the queue is full
// ----------------------------------------------------------------------------
module immix_block_line_sweep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ibls_pkg::req_type              req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ibls_pkg::rsp_type              rsp_word,
   input  logic                           csr_we,
   input  logic [ibls_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ibls_pkg::CSR_W-1:0]     csr_wdata
);

   logic                push;
   logic                pop;
   ibls_pkg::item_type  push_item;
   ibls_pkg::item_type  head_item;
   ibls_pkg::qstat_type qstat;

   ibls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   ibls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (qstat)
   );

   ibls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// File: src/ibls_checker.sv
// ----------------------------------------------------------------------------
// ibls_checker
// port-level checks on the sweep event stream
// ----------------------------------------------------------------------------
`include "immix_block_line_sweep_defines.svh"

module ibls_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ibls_pkg::rsp_type rsp_word
);

   `IBLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `IBLS_ASSERT_NOW(a_done_last, clock, reset, rsp_valid && rsp_word.event_res == ibls_pkg::EV_DONE, rsp_word.last)
   `IBLS_ASSERT_NOW(a_end_mark, clock, reset, rsp_valid && rsp_word.is_end_marker, rsp_word.event_res == ibls_pkg::EV_NEXT && rsp_word.value == ibls_pkg::END_MARK)
   `IBLS_ASSERT_NOW(a_outcome_done, clock, reset, rsp_valid && rsp_word.event_res != ibls_pkg::EV_DONE, rsp_word.block_outcome == ibls_pkg::OC_FREE)

endmodule

bind immix_block_line_sweep ibls_checker u_ibls_checker (.*);

// File: tb/sv/tb_immix_block_line_sweep.sv
// ----------------------------------------------------------------------------
// tb_immix_block_line_sweep
// self-checking bench for the block line sweeper: line and clear words go in
// from a send queue, a behavioral sweep model predicts every event word, and
// the event words coming out are checked field by field in arrival order.
// sweeps a holed block, then a block of holed, mixed-mark, marked and free
// runs under several line/block byte sizes, random sender gaps and receiver
// stalls, and one long receiver hold that backs the block up into its input
// ----------------------------------------------------------------------------
module tb_immix_block_line_sweep;

   typedef enum int {BLK_FREE, BLK_FULL, BLK_HOLES, BLK_MIXED} block_kind_type;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   ibls_pkg::req_type              req_word  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   ibls_pkg::rsp_type              rsp_word;
   logic                           csr_we    = 1'b0;
   logic [ibls_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ibls_pkg::CSR_W-1:0]     csr_wdata = '0;

   ibls_pkg::req_type lines_to_send[$];
   ibls_pkg::rsp_type events_due[$];
   ibls_pkg::rsp_type item_events[$];
   ibls_pkg::rsp_type due_word;

   int  idle_pct   = 0;
   int  stall_pct  = 0;
   bit  hold_armed = 1'b0;
   bit  hold_done  = 1'b0;
   int  hold_left  = 0;
   bit  failed     = 1'b0;
   int  cycles     = 0;
   int  gen_pos    = 0;
   bit  gen_hole   = 1'b0;

   // sweep model state
   logic [ibls_pkg::LBYTES_W-1:0] line_credit     = ibls_pkg::LINE_BYTES_RST;
   logic [ibls_pkg::BBYTES_W-1:0] block_credit    = ibls_pkg::BLOCK_BYTES_RST;
   logic [ibls_pkg::LC_W-1:0]     sweep_pos       = '0;
   logic                          hole_open       = 1'b0;
   logic                          block_has_hole  = 1'b0;
   logic [ibls_pkg::LC_W-1:0]     hole_first      = '0;
   logic [ibls_pkg::LC_W-1:0]     hole_len        = '0;
   logic [ibls_pkg::BYTES_W-1:0]  bytes_free      = '0;
   logic [ibls_pkg::COUNT_W-1:0]  blocks_free     = '0;
   logic [ibls_pkg::COUNT_W-1:0]  blocks_recycled = '0;

   immix_block_line_sweep u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void note_event(ibls_pkg::event_type ev,
                                      logic [ibls_pkg::LC_W-1:0] at,
                                      logic [ibls_pkg::LC_W-1:0] val, logic endm,
                                      ibls_pkg::outcome_type oc);
      ibls_pkg::rsp_type r;
      r               = '0;
      r.event_res     = ev;
      r.line_at       = at[ibls_pkg::AT_W-1:0];
      r.value         = val;
      r.is_end_marker = endm;
      r.block_outcome = oc;
      item_events.push_back(r);
   endfunction

   function automatic void credit_bytes(logic [ibls_pkg::BYTES_W-1:0] amount);
      if (amount >= ibls_pkg::BYTES_MAX - bytes_free) begin
         bytes_free = ibls_pkg::BYTES_MAX;
      end else begin
         bytes_free = bytes_free + amount;
      end
   endfunction

   function automatic logic [ibls_pkg::COUNT_W-1:0] bump(
      logic [ibls_pkg::COUNT_W-1:0] c);
      return (c == ibls_pkg::COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic void restart_block();
      sweep_pos      = '0;
      hole_open      = 1'b0;
      block_has_hole = 1'b0;
      hole_first     = '0;
      hole_len       = '0;
   endfunction

   function automatic void predict_sweep(ibls_pkg::req_type w);
      ibls_pkg::rsp_type r;
      logic              at_end;
      item_events.delete();
      if (w.command == ibls_pkg::CMD_CLEAR) begin
         bytes_free      = '0;
         blocks_free     = '0;
         blocks_recycled = '0;
         return;
      end
      at_end = (sweep_pos >= ibls_pkg::LAST_LINE);
      if (!w.block_marked) begin
         if (at_end) begin
            note_event(ibls_pkg::EV_DONE, sweep_pos, '0, 1'b0, ibls_pkg::OC_FREE);
            credit_bytes(ibls_pkg::BYTES_W'(block_credit));
            blocks_free = bump(blocks_free);
            restart_block();
         end else begin
            sweep_pos = sweep_pos + 1'b1;
         end
      end else begin
         if (w.line_marked) begin
            if (hole_open) begin
               note_event(ibls_pkg::EV_SIZE, hole_first, hole_len, 1'b0,
                          ibls_pkg::OC_FREE);
               hole_open = 1'b0;
            end
            note_event(ibls_pkg::EV_SWEEP, sweep_pos, '0, 1'b0, ibls_pkg::OC_FREE);
         end else begin
            if (!hole_open) begin
               if (!block_has_hole) begin
                  note_event(ibls_pkg::EV_FIRST, sweep_pos, sweep_pos, 1'b0,
                             ibls_pkg::OC_FREE);
               end else begin
                  note_event(ibls_pkg::EV_NEXT, hole_first, sweep_pos, 1'b0,
                             ibls_pkg::OC_FREE);
               end
               hole_first     = sweep_pos;
               hole_open      = 1'b1;
               block_has_hole = 1'b1;
               hole_len       = '0;
            end
            note_event(ibls_pkg::EV_CLEAR, sweep_pos, '0, 1'b0, ibls_pkg::OC_FREE);
            hole_len = hole_len + 1'b1;
            credit_bytes(ibls_pkg::BYTES_W'(line_credit));
         end
         if (at_end) begin
            if (hole_open) begin
               note_event(ibls_pkg::EV_SIZE, hole_first, hole_len, 1'b0,
                          ibls_pkg::OC_FREE);
            end
            if (block_has_hole) begin
               note_event(ibls_pkg::EV_NEXT, hole_first, ibls_pkg::END_MARK, 1'b1,
                          ibls_pkg::OC_FREE);
               note_event(ibls_pkg::EV_DONE, sweep_pos, '0, 1'b0,
                          ibls_pkg::OC_RECYCLABLE);
               blocks_recycled = bump(blocks_recycled);
            end else begin
               note_event(ibls_pkg::EV_DONE, sweep_pos, '0, 1'b0,
                          ibls_pkg::OC_UNAVAILABLE);
            end
            restart_block();
         end else begin
            sweep_pos = sweep_pos + 1'b1;
         end
      end
      foreach (item_events[k]) begin
         r                      = item_events[k];
         r.free_bytes_total     = bytes_free;
         r.free_block_count     = blocks_free;
         r.recycled_block_count = blocks_recycled;
         r.last                 = (k == item_events.size() - 1);
         events_due.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   function automatic void add_line(logic bm, logic lm);
      lines_to_send.push_back(ibls_pkg::req_type'{command: ibls_pkg::CMD_LINE,
                                                  block_marked: bm, line_marked: lm});
      gen_pos = (gen_pos + 1) % ibls_pkg::LINES_PER_BLOCK;
   endfunction

   function automatic void add_clear(logic bm, logic lm);
      lines_to_send.push_back(ibls_pkg::req_type'{command: ibls_pkg::CMD_CLEAR,
                                                  block_marked: bm, line_marked: lm});
   endfunction

   // one-kind lines and random clears until the block position reaches stop_at
   function automatic void sweep_fill(block_kind_type kind, int stop_at);
      logic bm;
      logic lm;
      logic tail;
      do begin
         if ($urandom_range(49) == 0) begin
            add_clear(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
         tail = (gen_pos == ibls_pkg::LINES_PER_BLOCK - 1);
         if ($urandom_range(3) == 0) begin
            gen_hole = !gen_hole;
         end
         unique case (kind)
            BLK_FREE: begin
               bm = 1'b0;
               lm = 1'($urandom_range(1));
            end
            BLK_FULL: begin
               bm = 1'b1;
               lm = 1'b1;
            end
            BLK_HOLES: begin
               bm = tail || ($urandom_range(19) != 0);
               lm = !gen_hole;
            end
            default: begin
               bm = !tail && ($urandom_range(4) != 0);
               lm = !gen_hole;
            end
         endcase
         add_line(bm, lm);
      end while (gen_pos != stop_at);
   endfunction

   task automatic write_reg(logic [ibls_pkg::CSR_IDX_W-1:0] idx,
                            logic [ibls_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == ibls_pkg::CSR_LINE_BYTES) begin
         line_credit = data[ibls_pkg::LBYTES_W-1:0];
      end else begin
         block_credit = data[ibls_pkg::BBYTES_W-1:0];
      end
   endtask

   task automatic set_sizes(int lb, int bb);
      write_reg(ibls_pkg::CSR_LINE_BYTES, ibls_pkg::CSR_W'(lb));
      write_reg(ibls_pkg::CSR_BLOCK_BYTES, ibls_pkg::CSR_W'(bb));
   endtask

   task automatic wait_drain();
      while (lines_to_send.size() != 0 || req_valid || events_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // line word driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_sweep(req_word);
         end
         if (!req_valid || !req_stall) begin
            if (lines_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_word  <= lines_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // event word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (events_due.size() == 0) begin
               $error("event word with none due: event_res %0d", rsp_word.event_res);
               failed = 1'b1;
            end else begin
               due_word = events_due.pop_front();
               check_field("event_res", due_word.event_res, rsp_word.event_res);
               check_field("line_at", due_word.line_at, rsp_word.line_at);
               check_field("value", due_word.value, rsp_word.value);
               check_field("is_end_marker", due_word.is_end_marker,
                           rsp_word.is_end_marker);
               check_field("block_outcome", due_word.block_outcome,
                           rsp_word.block_outcome);
               check_field("free_bytes_total", due_word.free_bytes_total,
                           rsp_word.free_bytes_total);
               check_field("free_block_count", due_word.free_block_count,
                           rsp_word.free_block_count);
               check_field("recycled_block_count", due_word.recycled_block_count,
                           rsp_word.recycled_block_count);
               check_field("last", due_word.last, rsp_word.last);
            end
         end
         if (hold_armed && !hold_done && rsp_valid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_immix_block_line_sweep NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset sizes, no idling
      add_clear(1'b1, 1'b1);
      add_line(1'b1, 1'b1);
      add_line(1'b1, 1'b0);
      add_line(1'b1, 1'b0);
      add_line(1'b0, 1'b1);
      add_line(1'b1, 1'b0);
      add_clear(1'b0, 1'b0);
      add_line(1'b1, 1'b1);
      add_line(1'b1, 1'b0);
      add_line(1'b1, 1'b1);
      add_line(1'b0, 1'b0);
      add_line(1'b1, 1'b1);
      sweep_fill(BLK_HOLES, ibls_pkg::LINES_PER_BLOCK - 2);
      // new hole on the last line: next link, clear, size, end marker, done
      add_line(1'b1, 1'b1);
      add_line(1'b1, 1'b0);
      wait_drain();

      set_sizes(1, 1);
      idle_pct  = 47;
      stall_pct = 0;
      sweep_fill(BLK_HOLES, 40);
      wait_drain();

      set_sizes(65536, 16777216);
      idle_pct  = 0;
      stall_pct = 47;
      sweep_fill(BLK_MIXED, 80);
      wait_drain();

      set_sizes($urandom_range(65536, 1), $urandom_range(16777216, 1));
      idle_pct  = 36;
      stall_pct = 36;
      sweep_fill(BLK_FULL, 96);
      wait_drain();

      // long receiver hold while lines keep coming, block ends unmarked
      set_sizes($urandom_range(65536, 1), $urandom_range(16777216, 1));
      idle_pct   = 0;
      stall_pct  = 0;
      hold_armed = 1'b1;
      sweep_fill(BLK_HOLES, ibls_pkg::LINES_PER_BLOCK - 2);
      sweep_fill(BLK_FREE, 0);
      wait_drain();

      if (failed) begin
         $display("tb_immix_block_line_sweep NOT OK");
      end else begin
         $display("tb_immix_block_line_sweep OK");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/ibls_pkg.sv
src/ibls_queue.sv
src/ibls_front.sv
src/ibls_back.sv
src/immix_block_line_sweep.sv
src/ibls_checker.sv
tb/sv/tb_immix_block_line_sweep.sv
